FILE: design/qemc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qemc_pkg: shared types and constants for the encoder to CC block
// Step codes, FSM states, register indexes and the transition table.
// ----------------------------------------------------------------------------
package qemc_pkg;

	localparam int ENCODERS_DEF = 16;
	localparam int PHASE_W      = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 64;

	localparam logic [3:0] CIN_CC    = 4'hb;
	localparam logic [7:0] STATUS_CC = 8'hb0;
	localparam logic [6:0] VAL_CW    = 7'h01;
	localparam logic [6:0] VAL_CCW   = 7'h7f;

	localparam logic [CFG_IDX_W-1:0] CFG_MIDI_CHANNEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_LOW      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_HIGH     = 2'd2;

	typedef enum logic [1:0] {
		STEP_NONE,
		STEP_CW,
		STEP_CCW
	} step_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	// transition index is {prev_b, prev_a, new_b, new_a}
	function automatic step_t step_lookup(input logic [3:0] idx);
		step_t s;
		unique case (idx)
			4'd2, 4'd13: s = STEP_CW;
			4'd7, 4'd8:  s = STEP_CCW;
			default:     s = STEP_NONE;
		endcase
		return s;
	endfunction

endpackage

FILE: design/qemc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qemc interfaces: scan input, CC message output and configuration write
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface qemc_in_if import qemc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               operation;
	logic [PHASE_W-1:0] phase_a;
	logic [PHASE_W-1:0] phase_b;
	modport source (output valid, operation, phase_a, phase_b, input ready);
	modport sink   (input valid, operation, phase_a, phase_b, output ready);
endinterface

interface qemc_out_if ();
	logic       valid;
	logic       ready;
	logic [3:0] code_index;
	logic [7:0] status;
	logic [7:0] controller;
	logic [6:0] value;
	logic       last;
	modport source (output valid, code_index, status, controller, value, last,
		input ready);
	modport sink   (input valid, code_index, status, controller, value, last,
		output ready);
endinterface

interface qemc_cfg_if import qemc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/qemc_step_dec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qemc_step_dec: quadrature transition decoder
// Maps one encoder's old and new phase pair to a step direction.
// ----------------------------------------------------------------------------
module qemc_step_dec import qemc_pkg::*; (
	input  logic  prev_a,
	input  logic  prev_b,
	input  logic  new_a,
	input  logic  new_b,
	output step_t step
);

	assign step = step_lookup({prev_b, prev_a, new_b, new_a});

endmodule

FILE: design/quadrature_encoders_to_midi_cc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_encoders_to_midi_cc: rotary encoders to relative MIDI CC
// Walks each scan's encoders one per cycle via a shared decoder, waiting on a
// step while the output is busy, and emits a control-change message per step.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                   | role
//  scan_in  | in  | operation, phase_a, phase_b               | scan / prime
//  cc_out   | out | code_index, status, controller, value, last| CC messages
//  cfg      | in  | index, data                               | register write
//
// A prime item loads the stored phases. A scan item passes the accept, the
// walk of each encoder through the shared step decoder, and a flush of the
// held message, stalling while a message is pending and the output is busy.
// Reset clears phases, registers and control. The last flag is known only
// once a later emit or the scan end is seen, so one message is held back.
// ----------------------------------------------------------------------------
module quadrature_encoders_to_midi_cc import qemc_pkg::*; #(
	parameter int ENCODERS = ENCODERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	qemc_in_if.sink     scan_in,
	qemc_out_if.source  cc_out,
	qemc_cfg_if.sink    cfg
);

	localparam int IW = (ENCODERS > 1) ? $clog2(ENCODERS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(ENCODERS - 1);

	// configuration registers
	logic [3:0]            midi_channel_q;
	logic [CFG_DATA_W-1:0] map_low_q;
	logic [CFG_DATA_W-1:0] map_high_q;

	// encoder state and scan working copy
	logic [ENCODERS-1:0] prev_a_q, prev_b_q;
	logic [ENCODERS-1:0] na_q, nb_q;
	logic [IW-1:0]       idx_q;
	state_t              state_q, state_d;

	// held message (last flag not yet known)
	logic       pend_v_q;
	logic [7:0] pend_ctrl_q;
	logic [6:0] pend_val_q;

	// output register
	logic       ov_q;
	logic [7:0] o_ctrl_q;
	logic [6:0] o_val_q;
	logic       o_last_q;

	logic       in_acc, out_free;
	logic       advance, load_pend, push_pend, flush_out;
	step_t      step;
	logic [7:0] cmap [16];

	assign cfg.ready     = 1'b1;
	assign scan_in.ready = (state_q == ST_IDLE);
	assign in_acc        = scan_in.valid && scan_in.ready;
	assign out_free      = !ov_q || cc_out.ready;

	// byte view of the controller maps, encoder 0 lowest
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			cmap[k]     = map_low_q[k*8 +: 8];
			cmap[k + 8] = map_high_q[k*8 +: 8];
		end
	end

	// shared decoder, steered by the encoder counter
	qemc_step_dec u_dec (
		.prev_a (prev_a_q[idx_q]),
		.prev_b (prev_b_q[idx_q]),
		.new_a  (na_q[idx_q]),
		.new_b  (nb_q[idx_q]),
		.step   (step)
	);

	// sequencer
	always_comb begin
		state_d   = state_q;
		advance   = 1'b0;
		load_pend = 1'b0;
		push_pend = 1'b0;
		flush_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && !scan_in.operation) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (step != STEP_NONE) begin
					// a new emit retires the held one with last cleared
					if (!pend_v_q || out_free) begin
						advance   = 1'b1;
						load_pend = 1'b1;
						push_pend = pend_v_q;
					end
				end else begin
					advance = 1'b1;
				end
				if (advance && idx_q == LAST_IDX) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (!pend_v_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					flush_out = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes; unknown index is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			midi_channel_q <= '0;
			map_low_q      <= '0;
			map_high_q     <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_MIDI_CHANNEL: midi_channel_q <= cfg.data[3:0];
				CFG_MAP_LOW:      map_low_q      <= cfg.data;
				CFG_MAP_HIGH:     map_high_q     <= cfg.data;
				default: ;
			endcase
		end
	end

	// stored phases: prime loads all, scan updates one encoder per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q <= '0;
			prev_b_q <= '0;
		end else if (in_acc && scan_in.operation) begin
			prev_a_q <= scan_in.phase_a[ENCODERS-1:0];
			prev_b_q <= scan_in.phase_b[ENCODERS-1:0];
		end else if (advance) begin
			prev_a_q[idx_q] <= na_q[idx_q];
			prev_b_q[idx_q] <= nb_q[idx_q];
		end
	end

	// scan working copy, masked by truncation to the encoder count
	always_ff @(posedge clk) begin
		if (in_acc) begin
			na_q <= scan_in.phase_a[ENCODERS-1:0];
			nb_q <= scan_in.phase_b[ENCODERS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (in_acc) begin
			idx_q <= '0;
		end else if (advance && idx_q != LAST_IDX) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// held message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (load_pend) begin
			pend_v_q <= 1'b1;
		end else if (flush_out) begin
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_pend) begin
			pend_ctrl_q <= cmap[4'(idx_q)];
			pend_val_q  <= (step == STEP_CW) ? VAL_CW : VAL_CCW;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (push_pend || flush_out) begin
			ov_q <= 1'b1;
		end else if (cc_out.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_pend || flush_out) begin
			o_ctrl_q <= pend_ctrl_q;
			o_val_q  <= pend_val_q;
			o_last_q <= flush_out;
		end
	end

	assign cc_out.valid      = ov_q;
	assign cc_out.code_index = CIN_CC;
	assign cc_out.status     = STATUS_CC | {4'h0, midi_channel_q};
	assign cc_out.controller = o_ctrl_q;
	assign cc_out.value      = o_val_q;
	assign cc_out.last       = o_last_q;

`ifndef SYNTH
	// nothing is held back between scans
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_v_q)
		else $error("held message left over in idle");

	// the output register is never overwritten while still occupied
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(push_pend || flush_out) |-> out_free)
		else $error("output register overwritten");

	// a scan item starts the encoder walk at encoder zero
	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !scan_in.operation) |=> (state_q == ST_SCAN && idx_q == '0))
		else $error("scan did not start at encoder zero");

	// the walk ends after the top encoder
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && advance && idx_q == LAST_IDX) |=> state_q == ST_FLUSH)
		else $error("scan did not end at the top encoder");
`endif

endmodule
